// ===== rtl/core/gaps_pkg.sv =====
package gaps_pkg;

   localparam int GRID_WIDTH     = 8;
   localparam int GRID_HEIGHT    = 8;
   localparam int MAX_NEIGHBOURS = 4;
   localparam int CELLS          = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_W         = $clog2(CELLS);
   localparam int CRD_W          = 4;
   localparam int STEP_W         = 6;
   localparam int WEIGHT_W       = $clog2(GRID_WIDTH + GRID_HEIGHT + 64);
   localparam int ROUTE_CAP      = 64;
   localparam int ROUTE_W        = $clog2(ROUTE_CAP);
   localparam int NCNT_W         = $clog2(MAX_NEIGHBOURS + 1);
   localparam int NTAB_W         = $clog2(CELLS * MAX_NEIGHBOURS);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;

   localparam logic [1:0] ST_ROUTE    = 2'd0;
   localparam logic [1:0] ST_UNREACH  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic [1:0] CSR_START_X  = 2'd0;
   localparam logic [1:0] CSR_START_Y  = 2'd1;
   localparam logic [1:0] CSR_TARGET_X = 2'd2;
   localparam logic [1:0] CSR_TARGET_Y = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [CRD_W-1:0] cell_x;
      logic [CRD_W-1:0] cell_y;
      logic [CRD_W-1:0] neighbour_x;
      logic [CRD_W-1:0] neighbour_y;
   } req_type;

   typedef struct packed {
      logic [CRD_W-1:0] route_x;
      logic [CRD_W-1:0] route_y;
      logic [1:0]       status;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_idx;
      logic [WEIGHT_W-1:0] weight;
   } qentry_type;

   typedef enum logic [2:0] {
      Q_HOLD,
      Q_INIT,
      Q_APPEND,
      Q_ROTATE,
      Q_REMOVE
   } qcmd_type;

   function automatic logic on_grid(input logic [CRD_W-1:0] x, input logic [CRD_W-1:0] y);
      return (x >= 1) && (int'(x) <= GRID_WIDTH) && (y >= 1) && (int'(y) <= GRID_HEIGHT);
   endfunction

   function automatic logic [CELL_W-1:0] cell_of(input logic [CRD_W-1:0] x,
                                                 input logic [CRD_W-1:0] y);
      return CELL_W'((int'(x) - 1) * GRID_HEIGHT + int'(y) - 1);
   endfunction

   function automatic logic [CRD_W-1:0] cell_col(input logic [CELL_W-1:0] c);
      return CRD_W'(int'(c) / GRID_HEIGHT + 1);
   endfunction

   function automatic logic [CRD_W-1:0] cell_row(input logic [CELL_W-1:0] c);
      return CRD_W'(int'(c) % GRID_HEIGHT + 1);
   endfunction

   function automatic logic [CRD_W-1:0] absdiff(input logic [CRD_W-1:0] a,
                                                input logic [CRD_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [WEIGHT_W-1:0] guess(input logic [CELL_W-1:0] c,
                                                 input logic [CRD_W-1:0] tx,
                                                 input logic [CRD_W-1:0] ty);
      return WEIGHT_W'(absdiff(cell_col(c), tx)) + WEIGHT_W'(absdiff(cell_row(c), ty));
   endfunction

endpackage

// ===== rtl/core/grid_astar_path_search_top.sv =====
// channel   | direction | handshake            | payload
// req_      | in        | req_valid/req_stall  | req_payload (op, cell, neighbour)
// rsp_      | out       | rsp_valid/rsp_stall  | rsp_payload (route cell, status, last)
// csr_      | in        | csr_valid/csr_ready  | csr_index, csr_data
// A load passes through S_LOAD_RD and S_LOAD_WR; a clear acts in S_IDLE. A run scans the open
// queue through the cell chain for the entry of lowest weight, removes it, expands that cell's
// list unless the target is reached, and at the end emits the route from the target to the start.
// Reset is synchronous; it invalidates the lists, clears state and queue length, sets endpoints to 1,1.
// req_stall is high while any transaction is in progress; a stalled result holds.
module grid_astar_path_search_top import gaps_pkg::*; #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data
);

   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD_RD, S_LOAD_WR, S_SCAN, S_REMOVE, S_FETCH,
      S_EXP_RD, S_EXP_PROC, S_ROUTE_RD, S_OUT
   } state_type;

   state_type state_ff;
   logic [CRD_W-1:0] start_x_ff, start_y_ff, target_x_ff, target_y_ff;
   logic [CELL_W-1:0] s_ff, t_ff, cur_ff, route_c_ff, ld_cell_ff, ld_nb_ff;
   logic [LEN_W-1:0] len_ff, scan_k_ff, best_ff;
   logic [WEIGHT_W-1:0] best_w_ff;
   logic [NCNT_W-1:0] ncount_ff, nk_ff;
   logic [STEP_W-1:0] steps_cur_ff;
   logic [ROUTE_W-1:0] route_n_ff;
   rsp_type rsp_ff;
   logic [CELLS-1:0] visited_ff, svalid_ff, cvalid_ff;

   logic [NCNT_W-1:0] cnt_mem [CELLS];
   logic [CELL_W-1:0] tbl_mem [CELLS*MAX_NEIGHBOURS];
   logic [STEP_W-1:0] step_mem [CELLS];
   logic [CELL_W-1:0] par_mem [CELLS];
   logic [NCNT_W-1:0] cnt_rd_ff;
   logic [CELL_W-1:0] tbl_rd_ff, par_rd_ff;
   logic [STEP_W-1:0] step_rd_ff;

   logic req_accept, grid_ok, append, q_full, ld_ok;
   logic [CELL_W-1:0] cnt_raddr, nb, s_cell, t_cell;
   logic [NCNT_W-1:0] ld_eff, fetch_eff;
   logic [NTAB_W-1:0] tbl_raddr, tbl_waddr;
   logic [STEP_W-1:0] steps_nb;
   qcmd_type q_cmd;
   qentry_type q_wr, q_head;
   logic route_last;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   assign s_cell  = cell_of(start_x_ff, start_y_ff);
   assign t_cell  = cell_of(target_x_ff, target_y_ff);
   assign grid_ok = on_grid(start_x_ff, start_y_ff) && on_grid(target_x_ff, target_y_ff);
   assign ld_ok   = on_grid(req_payload.cell_x, req_payload.cell_y)
                    && on_grid(req_payload.neighbour_x, req_payload.neighbour_y);

   assign cnt_raddr = (state_ff == S_LOAD_RD) ? ld_cell_ff : cur_ff;
   assign ld_eff    = cvalid_ff[ld_cell_ff] ? cnt_rd_ff : '0;
   assign fetch_eff = cvalid_ff[cur_ff] ? cnt_rd_ff : '0;
   assign tbl_raddr = NTAB_W'(int'(cur_ff) * MAX_NEIGHBOURS + int'(nk_ff));
   assign tbl_waddr = NTAB_W'(int'(ld_cell_ff) * MAX_NEIGHBOURS + int'(ld_eff));

   assign nb       = tbl_rd_ff;
   assign q_full   = (int'(len_ff) >= QUEUE_DEPTH);
   assign append   = (state_ff == S_EXP_PROC) && !visited_ff[nb] && !q_full;
   assign steps_nb = STEP_W'(steps_cur_ff + 1'b1);
   assign route_last = (route_c_ff == s_ff) || (int'(route_n_ff) == ROUTE_CAP - 1);

   always_comb begin
      q_cmd = Q_HOLD;
      q_wr  = '{cell_idx: nb,
                weight: WEIGHT_W'(guess(nb, target_x_ff, target_y_ff)
                                  + WEIGHT_W'(steps_cur_ff) + 1'b1)};
      if (state_ff == S_IDLE && req_accept && req_payload.op == OP_RUN && grid_ok) begin
         q_cmd = Q_INIT;
         q_wr  = '{cell_idx: s_cell, weight: guess(s_cell, target_x_ff, target_y_ff)};
      end else if (state_ff == S_SCAN && len_ff != '0) begin
         q_cmd = Q_ROTATE;
      end else if (state_ff == S_REMOVE) begin
         q_cmd = Q_REMOVE;
      end else if (append) begin
         q_cmd = Q_APPEND;
      end
   end

   gaps_open_queue #(
      .DEPTH (QUEUE_DEPTH),
      .LEN_W (LEN_W)
   ) u_queue (
      .clock      (clock),
      .cmd        (q_cmd),
      .len        (len_ff),
      .best       (best_ff),
      .wr_entry   (q_wr),
      .head_entry (q_head)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD_WR && int'(ld_eff) < MAX_NEIGHBOURS) begin
         cnt_mem[ld_cell_ff] <= NCNT_W'(ld_eff + 1'b1);
         tbl_mem[tbl_waddr]  <= ld_nb_ff;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (append) begin
         step_mem[nb] <= steps_nb;
         par_mem[nb]  <= cur_ff;
      end
      step_rd_ff <= step_mem[cur_ff];
      par_rd_ff  <= par_mem[route_c_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         start_x_ff  <= CRD_W'(1);
         start_y_ff  <= CRD_W'(1);
         target_x_ff <= CRD_W'(1);
         target_y_ff <= CRD_W'(1);
         cvalid_ff   <= '0;
         visited_ff  <= '0;
         svalid_ff   <= '0;
         len_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_START_X:  start_x_ff  <= csr_data;
               CSR_START_Y:  start_y_ff  <= csr_data;
               CSR_TARGET_X: target_x_ff <= csr_data;
               CSR_TARGET_Y: target_y_ff <= csr_data;
               default:      start_x_ff  <= start_x_ff;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  unique case (req_payload.op)
                     OP_ADD: begin
                        if (ld_ok) begin
                           ld_cell_ff <= cell_of(req_payload.cell_x, req_payload.cell_y);
                           ld_nb_ff   <= cell_of(req_payload.neighbour_x,
                                                 req_payload.neighbour_y);
                           state_ff   <= S_LOAD_RD;
                        end
                     end
                     OP_CLEAR: begin
                        cvalid_ff <= '0;
                     end
                     OP_RUN: begin
                        if (!grid_ok) begin
                           rsp_ff   <= '{route_x: '0, route_y: '0, status: ST_UNREACH,
                                         last: 1'b1};
                           state_ff <= S_OUT;
                        end else begin
                           s_ff       <= s_cell;
                           t_ff       <= t_cell;
                           visited_ff <= '0;
                           svalid_ff  <= '0;
                           len_ff     <= LEN_W'(1);
                           scan_k_ff  <= '0;
                           state_ff   <= S_SCAN;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_LOAD_RD: begin
               state_ff <= S_LOAD_WR;
            end
            S_LOAD_WR: begin
               if (int'(ld_eff) < MAX_NEIGHBOURS) cvalid_ff[ld_cell_ff] <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               if (len_ff == '0) begin
                  if (visited_ff[t_ff]) begin
                     route_c_ff <= t_ff;
                     route_n_ff <= '0;
                     state_ff   <= S_ROUTE_RD;
                  end else begin
                     rsp_ff   <= '{route_x: '0, route_y: '0, status: ST_UNREACH, last: 1'b1};
                     state_ff <= S_OUT;
                  end
               end else begin
                  if (scan_k_ff == '0 || q_head.weight < best_w_ff) begin
                     best_w_ff <= q_head.weight;
                     best_ff   <= scan_k_ff;
                     cur_ff    <= q_head.cell_idx;
                  end
                  if (scan_k_ff == LEN_W'(len_ff - 1'b1)) begin
                     scan_k_ff <= '0;
                     state_ff  <= S_REMOVE;
                  end else begin
                     scan_k_ff <= LEN_W'(scan_k_ff + 1'b1);
                  end
               end
            end
            S_REMOVE: begin
               len_ff             <= LEN_W'(len_ff - 1'b1);
               visited_ff[cur_ff] <= 1'b1;
               state_ff <= (visited_ff[t_ff] || cur_ff == t_ff) ? S_SCAN : S_FETCH;
            end
            S_FETCH: begin
               ncount_ff    <= fetch_eff;
               steps_cur_ff <= svalid_ff[cur_ff] ? step_rd_ff : '0;
               nk_ff        <= '0;
               state_ff     <= S_EXP_RD;
            end
            S_EXP_RD: begin
               if (nk_ff == ncount_ff) begin
                  cvalid_ff[cur_ff] <= 1'b0;
                  state_ff          <= S_SCAN;
               end else begin
                  state_ff <= S_EXP_PROC;
               end
            end
            S_EXP_PROC: begin
               nk_ff <= NCNT_W'(nk_ff + 1'b1);
               if (!visited_ff[nb]) begin
                  if (nb == t_ff) visited_ff[t_ff] <= 1'b1;
                  if (q_full) begin
                     cvalid_ff[cur_ff] <= 1'b0;
                     rsp_ff   <= '{route_x: '0, route_y: '0, status: ST_OVERFLOW, last: 1'b1};
                     state_ff <= S_OUT;
                  end else begin
                     len_ff        <= LEN_W'(len_ff + 1'b1);
                     svalid_ff[nb] <= 1'b1;
                     state_ff      <= S_EXP_RD;
                  end
               end else begin
                  state_ff <= S_EXP_RD;
               end
            end
            S_ROUTE_RD: begin
               rsp_ff     <= '{route_x: cell_col(route_c_ff), route_y: cell_row(route_c_ff),
                               status: ST_ROUTE, last: route_last};
               route_n_ff <= ROUTE_W'(route_n_ff + 1'b1);
               state_ff   <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (rsp_ff.last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     route_c_ff <= par_rd_ff;
                     state_ff   <= S_ROUTE_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/gaps_q_cell.sv =====
module gaps_q_cell import gaps_pkg::*; #(
   parameter int IDX   = 0,
   parameter int LEN_W = 9
) (
   input  logic             clock,
   input  qcmd_type         cmd,
   input  logic [LEN_W-1:0] len,
   input  logic [LEN_W-1:0] best,
   input  qentry_type       next_entry,
   input  qentry_type       head_entry,
   input  qentry_type       wr_entry,
   output qentry_type       entry
);

   localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

   qentry_type entry_ff;
   qentry_type entry_in;
   logic [LEN_W-1:0] tail_idx;

   assign tail_idx = LEN_W'(len - 1'b1);

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd)
         Q_HOLD: begin
            entry_in = entry_ff;
         end
         Q_INIT: begin
            if (MY_IDX == '0) entry_in = wr_entry;
         end
         Q_APPEND: begin
            if (MY_IDX == len) entry_in = wr_entry;
         end
         Q_ROTATE: begin
            entry_in = (MY_IDX == tail_idx) ? head_entry : next_entry;
         end
         Q_REMOVE: begin
            if (MY_IDX >= best) entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/gaps_open_queue.sv =====
module gaps_open_queue import gaps_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int LEN_W = 9
) (
   input  logic             clock,
   input  qcmd_type         cmd,
   input  logic [LEN_W-1:0] len,
   input  logic [LEN_W-1:0] best,
   input  qentry_type       wr_entry,
   output qentry_type       head_entry
);

   qentry_type entries [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      qentry_type nxt;
      if (i == DEPTH - 1) begin : g_end
         assign nxt = entries[i];
      end else begin : g_mid
         assign nxt = entries[i+1];
      end
      gaps_q_cell #(
         .IDX   (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .len        (len),
         .best       (best),
         .next_entry (nxt),
         .head_entry (entries[0]),
         .wr_entry   (wr_entry),
         .entry      (entries[i])
      );
   end

   assign head_entry = entries[0];

endmodule

// ===== rtl/core/gaps_checker.sv =====
module gaps_checker import gaps_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_flag_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_ROUTE |->
         rsp_payload.last && rsp_payload.route_x == '0 && rsp_payload.route_y == '0)
      else $error("flagged result malformed");

   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_route_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_ROUTE |->
         rsp_payload.route_x != '0 && rsp_payload.route_y != '0)
      else $error("route cell off grid");

endmodule

bind grid_astar_path_search_top gaps_checker u_gaps_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
   import gaps_pkg::*;

   localparam int QDEPTH   = 256;
   localparam int WD_LIMIT = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_data = '0;

   grid_astar_path_search_top #(.QUEUE_DEPTH(QDEPTH)) u_dut (.*);

   always #1 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type route_expect[$];
   int      errors = 0;
   int      send_gap = 0;
   int      stall_gap = 0;
   int      hold_cycles = 0;
   bit      hold_request = 1'b0;
   int      idle_cycles = 0;

   int      cfg_sx = 1, cfg_sy = 1, cfg_tx = 1, cfg_ty = 1;
   int      adj_cell[CELLS][MAX_NEIGHBOURS];
   int      adj_count[CELLS];
   int      route_parent[CELLS];
   int      route_steps[CELLS];
   bit      seen[CELLS];

   task automatic report(string what, int got, int want);
      $display("tb: mismatch %s got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit grid_ok(int x, int y);
      return x >= 1 && x <= GRID_WIDTH && y >= 1 && y <= GRID_HEIGHT;
   endfunction

   function automatic int heuristic(int c);
      int x, y, dx, dy;
      x = c / GRID_HEIGHT + 1;
      y = c % GRID_HEIGHT + 1;
      dx = (x > cfg_tx) ? x - cfg_tx : cfg_tx - x;
      dy = (y > cfg_ty) ? y - cfg_ty : cfg_ty - y;
      return dx + dy;
   endfunction

   task automatic expect_rsp(int x, int y, logic [1:0] st, bit lst);
      rsp_type r;
      r.route_x = CRD_W'(x);
      r.route_y = CRD_W'(y);
      r.status = st;
      r.last = lst;
      route_expect.push_back(r);
   endtask

   task automatic search_route();
      int qc[$];
      int qw[$];
      int s, t, cur, best, nb, c, n;
      bit done;
      if (!grid_ok(cfg_sx, cfg_sy) || !grid_ok(cfg_tx, cfg_ty)) begin
         expect_rsp(0, 0, ST_UNREACH, 1'b1);
         return;
      end
      s = (cfg_sx - 1) * GRID_HEIGHT + cfg_sy - 1;
      t = (cfg_tx - 1) * GRID_HEIGHT + cfg_ty - 1;
      foreach (seen[i]) begin
         seen[i] = 1'b0;
         route_steps[i] = 0;
      end
      qc.push_back(s);
      qw.push_back(heuristic(s));
      while (qc.size() > 0) begin
         best = 0;
         for (int i = 1; i < qc.size(); i++)
            if (qw[i] < qw[best]) best = i;
         cur = qc[best];
         qc.delete(best);
         qw.delete(best);
         seen[cur] = 1'b1;
         if (seen[t]) continue;
         for (int k = 0; k < adj_count[cur]; k++) begin
            nb = adj_cell[cur][k];
            if (seen[nb]) continue;
            if (nb == t) seen[t] = 1'b1;
            if (qc.size() >= QDEPTH) begin
               adj_count[cur] = 0;
               expect_rsp(0, 0, ST_OVERFLOW, 1'b1);
               return;
            end
            qc.push_back(nb);
            qw.push_back(heuristic(nb) + route_steps[cur] + 1);
            route_parent[nb] = cur;
            route_steps[nb] = (route_steps[cur] + 1) & 63;
         end
         adj_count[cur] = 0;
      end
      if (!seen[t]) begin
         expect_rsp(0, 0, ST_UNREACH, 1'b1);
         return;
      end
      c = t;
      n = 0;
      while (n < ROUTE_CAP) begin
         done = (c == s) || (n == ROUTE_CAP - 1);
         expect_rsp(c / GRID_HEIGHT + 1, c % GRID_HEIGHT + 1, ST_ROUTE, done);
         n++;
         if (done) break;
         c = route_parent[c];
      end
   endtask

   task automatic apply_item(req_type it);
      int c;
      case (it.op)
         OP_ADD: begin
            if (grid_ok(it.cell_x, it.cell_y) && grid_ok(it.neighbour_x, it.neighbour_y)) begin
               c = (int'(it.cell_x) - 1) * GRID_HEIGHT + int'(it.cell_y) - 1;
               if (adj_count[c] < MAX_NEIGHBOURS) begin
                  adj_cell[c][adj_count[c]] =
                     (int'(it.neighbour_x) - 1) * GRID_HEIGHT + int'(it.neighbour_y) - 1;
                  adj_count[c]++;
               end
            end
         end
         OP_CLEAR: foreach (adj_count[i]) adj_count[i] = 0;
         OP_RUN: search_route();
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      logic    nxt_valid;
      req_type nxt_payload;
      nxt_valid = req_valid;
      nxt_payload = req_payload;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_item(req_payload);
            nxt_valid = 1'b0;
            send_gap = pick_gap();
         end
         if (!nxt_valid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_reqs.size() > 0) begin
               nxt_payload = pending_reqs.pop_front();
               nxt_valid = 1'b1;
            end
         end
      end
      req_valid <= nxt_valid;
      req_payload <= nxt_payload;
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      logic    nxt_stall;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (route_expect.size() == 0) report("unexpected transaction", 0, 0);
         else begin
            want = route_expect.pop_front();
            if (rsp_payload.route_x !== want.route_x)
               report("route_x", rsp_payload.route_x, want.route_x);
            if (rsp_payload.route_y !== want.route_y)
               report("route_y", rsp_payload.route_y, want.route_y);
            if (rsp_payload.status !== want.status)
               report("status", rsp_payload.status, want.status);
            if (rsp_payload.last !== want.last)
               report("last", rsp_payload.last, want.last);
         end
      end
      if (hold_request && hold_cycles == 0) hold_cycles = 400;
      if (hold_cycles > 0) begin
         hold_cycles--;
         if (hold_cycles == 0) hold_request = 1'b0;
         nxt_stall = 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         nxt_stall = 1'b1;
      end else begin
         stall_gap = pick_gap();
         nxt_stall = 1'b0;
      end
      rsp_stall <= nxt_stall;
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 4'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_X:  cfg_sx = val;
         CSR_START_Y:  cfg_sy = val;
         CSR_TARGET_X: cfg_tx = val;
         default:      cfg_ty = val;
      endcase
   endtask

   task automatic set_endpoints(int sx, int sy, int tx, int ty);
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_TARGET_X, tx);
      write_csr(CSR_TARGET_Y, ty);
   endtask

   task automatic push_req(logic [1:0] op, int cx, int cy, int nx, int ny);
      req_type it;
      it.op = op;
      it.cell_x = 4'(cx);
      it.cell_y = 4'(cy);
      it.neighbour_x = 4'(nx);
      it.neighbour_y = 4'(ny);
      pending_reqs.push_back(it);
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_valid && route_expect.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_walk(int len);
      int x, y, nx, ny;
      x = cfg_sx;
      y = cfg_sy;
      for (int k = 0; k < len; k++) begin
         nx = x;
         ny = y;
         if ($urandom_range(0, 2) != 0) begin
            if (x != cfg_tx) nx = (cfg_tx > x) ? x + 1 : x - 1;
            else if (y != cfg_ty) ny = (cfg_ty > y) ? y + 1 : y - 1;
         end else begin
            case ($urandom_range(0, 3))
               0: nx = x + 1;
               1: nx = x - 1;
               2: ny = y + 1;
               default: ny = y - 1;
            endcase
         end
         if (!grid_ok(nx, ny)) continue;
         push_req(OP_ADD, x, y, nx, ny);
         if ($urandom_range(0, 3) == 0) push_req(OP_ADD, nx, ny, x, y);
         x = nx;
         y = ny;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_req(OP_RUN, 0, 0, 0, 0);
      push_req(2'd3, 15, 15, 15, 15);
      push_req(OP_ADD, 1, 1, 1, 2);
      push_req(OP_ADD, 1, 1, 2, 1);
      push_req(OP_ADD, 1, 1, 1, 2);
      push_req(OP_ADD, 1, 1, 2, 2);
      push_req(OP_ADD, 1, 1, 8, 8);
      push_req(OP_ADD, 0, 1, 1, 2);
      push_req(OP_ADD, 9, 8, 1, 2);
      push_req(OP_ADD, 1, 2, 8, 15);
      push_req(OP_ADD, 2, 1, 8, 8);
      wait_idle();
      set_endpoints(1, 1, 8, 8);
      push_req(OP_RUN, 0, 0, 0, 0);
      push_req(OP_RUN, 0, 0, 0, 0);
      push_req(OP_CLEAR, 0, 0, 0, 0);
      push_req(OP_RUN, 0, 0, 0, 0);
      wait_idle();
      set_endpoints(0, 8, 8, 1);
      push_req(OP_RUN, 0, 0, 0, 0);
      wait_idle();
      set_endpoints(8, 8, 15, 9);
      push_req(OP_RUN, 0, 0, 0, 0);
      wait_idle();

      // random phases
      for (int ph = 0; ph < 11; ph++) begin
         int sx, sy, tx, ty;
         sx = $urandom_range(1, 8);
         sy = $urandom_range(1, 8);
         tx = $urandom_range(1, 8);
         ty = $urandom_range(1, 8);
         if ($urandom_range(0, 9) == 0) sx = $urandom_range(0, 15);
         if ($urandom_range(0, 9) == 0) ty = $urandom_range(0, 15);
         set_endpoints(sx, sy, tx, ty);
         if ($urandom_range(0, 3) != 0) push_req(OP_CLEAR, 0, 0, 0, 0);
         push_walk($urandom_range(8, 20));
         for (int k = 0; k < 4; k++)
            push_req($urandom_range(0, 3) == 0 ? 2'($urandom_range(0, 3)) : OP_ADD,
                     $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15));
         push_req(OP_RUN, 0, 0, 0, 0);
         if (ph == 5) begin
            hold_request = 1'b1;
            for (int k = 0; k < 5; k++) begin
               push_walk(6);
               push_req(OP_RUN, 0, 0, 0, 0);
            end
         end
         wait_idle();
      end

      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== grid_astar_path_search_top.f =====
rtl/core/gaps_pkg.sv
rtl/core/gaps_q_cell.sv
rtl/core/gaps_open_queue.sv
rtl/core/grid_astar_path_search_top.sv
rtl/core/gaps_checker.sv
test/tb_top.sv
